// ----- sv/keyed_byte_stream_hash_macros.svh -----
// Assertion helpers for the keyed byte stream hash.
// Assertions sample on clk_i and are disabled while rst_ni is low.
`ifndef KEYED_BYTE_STREAM_HASH_MACROS_SVH
`define KEYED_BYTE_STREAM_HASH_MACROS_SVH

`ifndef SYNTH
`define KBSH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kbsh assertion failed");
`define KBSH_ASSERT_IMP(lbl, ante, cons) `KBSH_ASSERT(lbl, ante |-> cons)
`define KBSH_ASSERT_NEXT(lbl, ante, cons) `KBSH_ASSERT(lbl, ante |=> cons)
`else
`define KBSH_ASSERT(lbl, prop)
`define KBSH_ASSERT_IMP(lbl, ante, cons)
`define KBSH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/kbsh_pkg.sv -----
package kbsh_pkg;

  localparam int unsigned WordWidth = 64;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned PosWidth  = 3;

  localparam logic [WordWidth-1:0] SipC0 = 64'h736f6d6570736575;
  localparam logic [WordWidth-1:0] SipC1 = 64'h646f72616e646f6d;
  localparam logic [WordWidth-1:0] SipC2 = 64'h6c7967656e657261;
  localparam logic [WordWidth-1:0] SipC3 = 64'h7465646279746573;
  localparam logic [WordWidth-1:0] SipFinalXor = 64'h00000000000000ff;

  typedef enum logic {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    OP_NONE       = 2'd0,
    OP_ACCEPT     = 2'd1,
    OP_LOAD_FINAL = 2'd2,
    OP_ROUND      = 2'd3
  } dp_op_e;

  // Command from the controller to the datapath, one per cycle.
  typedef struct packed {
    dp_op_e op;
    logic   half;          // 0: first half of a SipRound, 1: second half
    logic   xor_word_in;   // fold the message word into lane three before the round
    logic   xor_word_out;  // fold the message word into lane zero after the round
    logic   xor_ff_in;     // finalization constant into lane two before the round
    logic   load_digest;   // capture the digest from the round result
  } dp_cmd_t;

  typedef struct packed {
    logic full_word;       // the byte on the input completes an eight-byte word
  } dp_status_t;

endpackage

// ----- sv/kbsh_ctrl.sv -----
`include "keyed_byte_stream_hash_macros.svh"

module kbsh_ctrl
  import kbsh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       byte_present_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ABSORB = 4'b0010,
    ST_FINAL  = 4'b0100,
    ST_ROUNDS = 4'b1000
  } state_e;

  localparam logic [2:0] CntAbsorbLast = 3'd3;
  localparam logic [2:0] CntFinishLast = 3'd7;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic       fin_q, fin_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    fin_d   = fin_q;
    cmd_o   = '{op: OP_NONE, default: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        // drop requests that carry neither a byte nor an end mark
        if (accept && (byte_present_i || end_of_message_i)) begin
          cmd_o.op = OP_ACCEPT;
          last_d   = end_of_message_i;
          fin_d    = 1'b0;
          cnt_d    = '0;
          if (status_i.full_word) begin
            state_d = ST_ABSORB;
          end else if (end_of_message_i) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_ABSORB: begin
        cmd_o.op           = OP_ROUND;
        cmd_o.half         = cnt_q[0];
        cmd_o.xor_word_in  = (cnt_q == '0);
        cmd_o.xor_word_out = (cnt_q == CntAbsorbLast);
        cnt_d              = cnt_q + 3'd1;
        if (cnt_q == CntAbsorbLast) begin
          cnt_d = '0;
          priority if (fin_q) begin
            state_d = ST_ROUNDS;
          end else if (last_q) begin
            state_d = ST_FINAL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FINAL: begin
        cmd_o.op = OP_LOAD_FINAL;
        fin_d    = 1'b1;
        state_d  = ST_ABSORB;
      end
      ST_ROUNDS: begin
        // hold the last round while the previous digest still waits
        if (!(cnt_q == CntFinishLast && out_valid_q && out_stall_i)) begin
          cmd_o.op        = OP_ROUND;
          cmd_o.half      = cnt_q[0];
          cmd_o.xor_ff_in = (cnt_q == '0);
          cnt_d           = cnt_q + 3'd1;
          if (cnt_q == CntFinishLast) begin
            cmd_o.load_digest = 1'b1;
            cnt_d             = '0;
            state_d           = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.load_digest) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  `KBSH_ASSERT_IMP(a_digest_no_overwrite, cmd_o.load_digest, !(out_valid_q && out_stall_i))
  `KBSH_ASSERT_NEXT(a_digest_sets_valid, cmd_o.load_digest, out_valid_q)
  `KBSH_ASSERT_NEXT(a_full_word_absorbs, (accept && status_i.full_word), (state_q == ST_ABSORB))
  `KBSH_ASSERT_NEXT(a_final_then_absorb, (state_q == ST_FINAL), (state_q == ST_ABSORB && fin_q))

endmodule

// ----- sv/kbsh_datapath.sv -----
module kbsh_datapath
  import kbsh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [WordWidth-1:0] cfg_wdata_i,
  input  logic [ByteWidth-1:0] data_byte_i,
  input  logic                 byte_present_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  output logic [WordWidth-1:0] digest_o
);

  logic [WordWidth-1:0] key_low_q, key_high_q;
  logic [WordWidth-1:0] v0_q, v1_q, v2_q, v3_q;
  logic [WordWidth-1:0] v0_d, v1_d, v2_d, v3_d;
  logic [WordWidth-1:0] pw_q, pw_d;
  logic [WordWidth-1:0] word_q, word_d;
  logic [WordWidth-1:0] digest_q, digest_d;
  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [7:0]           len_q, len_d;
  logic                 in_msg_q, in_msg_d;

  // message start view: fresh counters when no message is open
  logic [PosWidth-1:0]  pos_eff;
  logic [7:0]           len_eff;
  logic [WordWidth-1:0] pw_eff;
  logic [WordWidth-1:0] pw_merged;

  // shared half-round
  logic [WordWidth-1:0] r_v2, r_v3;
  logic [WordWidth-1:0] ra, rb, rc, rd;
  logic [WordWidth-1:0] ra1, rc1, rb1, rd1, ra2;
  logic [WordWidth-1:0] rb_rot, rd_rot;
  logic [WordWidth-1:0] n0, n1, n2, n3;

  assign pos_eff   = in_msg_q ? pos_q : '0;
  assign len_eff   = in_msg_q ? len_q : '0;
  assign pw_eff    = in_msg_q ? pw_q : '0;
  assign pw_merged = pw_eff | ({{(WordWidth-ByteWidth){1'b0}}, data_byte_i}
                               << {pos_eff, 3'b000});

  assign status_o.full_word = byte_present_i && (pos_eff == {PosWidth{1'b1}});
  assign digest_o = digest_q;

  assign r_v2 = v2_q ^ (cmd_i.xor_ff_in ? SipFinalXor : '0);
  assign r_v3 = v3_q ^ (cmd_i.xor_word_in ? word_q : '0);

  // second half is the first with lanes zero and two swapped, and its own rotations
  assign ra  = cmd_i.half ? r_v2 : v0_q;
  assign rb  = v1_q;
  assign rc  = cmd_i.half ? v0_q : r_v2;
  assign rd  = r_v3;
  assign ra1 = ra + rb;
  assign rc1 = rc + rd;
  assign rb_rot = cmd_i.half ? {rb[46:0], rb[63:47]} : {rb[50:0], rb[63:51]};
  assign rd_rot = cmd_i.half ? {rd[42:0], rd[63:43]} : {rd[47:0], rd[63:48]};
  assign rb1 = rb_rot ^ ra1;
  assign rd1 = rd_rot ^ rc1;
  assign ra2 = {ra1[31:0], ra1[63:32]};

  always_comb begin
    n1 = rb1;
    n3 = rd1;
    if (cmd_i.half) begin
      n0 = rc1;
      n2 = ra2;
    end else begin
      n0 = ra2;
      n2 = rc1;
    end
    if (cmd_i.xor_word_out) begin
      n0 = n0 ^ word_q;
    end
  end

  always_comb begin
    v0_d     = v0_q;
    v1_d     = v1_q;
    v2_d     = v2_q;
    v3_d     = v3_q;
    pw_d     = pw_q;
    word_d   = word_q;
    pos_d    = pos_q;
    len_d    = len_q;
    in_msg_d = in_msg_q;
    digest_d = digest_q;
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        if (!in_msg_q) begin
          v0_d = key_low_q ^ SipC0;
          v1_d = key_high_q ^ SipC1;
          v2_d = key_low_q ^ SipC2;
          v3_d = key_high_q ^ SipC3;
        end
        in_msg_d = 1'b1;
        pw_d     = pw_eff;
        pos_d    = pos_eff;
        len_d    = len_eff;
        if (byte_present_i) begin
          pw_d  = pw_merged;
          pos_d = pos_eff + 3'd1;
          len_d = len_eff + 8'd1;
          if (status_o.full_word) begin
            word_d = pw_merged;
            pw_d   = '0;
          end
        end
      end
      OP_LOAD_FINAL: begin
        word_d   = pw_q | {len_q, {(WordWidth-8){1'b0}}};
        pw_d     = '0;
        pos_d    = '0;
        len_d    = '0;
        in_msg_d = 1'b0;
      end
      OP_ROUND: begin
        v0_d = n0;
        v1_d = n1;
        v2_d = n2;
        v3_d = n3;
        if (cmd_i.load_digest) begin
          digest_d = n0 ^ n1 ^ n2 ^ n3;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      v0_q       <= SipC0;
      v1_q       <= SipC1;
      v2_q       <= SipC2;
      v3_q       <= SipC3;
      pos_q      <= '0;
      len_q      <= '0;
      in_msg_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_index_e'(cfg_index_i))
          REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
          REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      v0_q     <= v0_d;
      v1_q     <= v1_d;
      v2_q     <= v2_d;
      v3_q     <= v3_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      in_msg_q <= in_msg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q     <= pw_d;
    word_q   <= word_d;
    digest_q <= digest_d;
  end

endmodule

// ----- sv/keyed_byte_stream_hash.sv -----
// SipHash-2-4 over a byte stream, one byte per request, one half SipRound per cycle;
//   a waiting digest can hold the last finalization half round. A byte that completes
//   a word stalls the input for four absorb half rounds; other bytes do not stall it. An
//   end mark stalls it for the final-word load, four absorb and eight finalization half
//   rounds, after the full-word absorb if it completes a word; then the digest is valid.
// Reset: keys clear to zero, no message is open, output valid drops; no clearing pass.
module keyed_byte_stream_hash
  import kbsh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [WordWidth-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ByteWidth-1:0] data_byte_i,
  input  logic                 byte_present_i,
  input  logic                 end_of_message_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WordWidth-1:0] digest_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  kbsh_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  kbsh_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .digest_o       (digest_o)
  );

endmodule

// ----- dv/kbsh_checker.sv -----
module kbsh_checker
  import kbsh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [WordWidth-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [ByteWidth-1:0] data_byte_i,
  input  logic                 byte_present_i,
  input  logic                 end_of_message_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [WordWidth-1:0] digest_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          digests_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WordWidth-1:0] v0;
    logic [WordWidth-1:0] v1;
    logic [WordWidth-1:0] v2;
    logic [WordWidth-1:0] v3;
  } lanes_t;

  logic [WordWidth-1:0] key_lo;
  logic [WordWidth-1:0] key_hi;
  lanes_t               lanes;
  logic [WordWidth-1:0] word_acc;
  logic [PosWidth-1:0]  slot;
  logic [7:0]           msg_len;
  logic                 msg_open;
  logic [WordWidth-1:0] want_digest;
  logic [WordWidth-1:0] pending_digests[$];

  function automatic logic [WordWidth-1:0] rotl(input logic [WordWidth-1:0] x,
                                                input int unsigned r);
    return (x << r) | (x >> (WordWidth - r));
  endfunction

  function automatic lanes_t sip_round(input lanes_t s);
    s.v0 = s.v0 + s.v1;
    s.v2 = s.v2 + s.v3;
    s.v1 = rotl(s.v1, 13);
    s.v3 = rotl(s.v3, 16);
    s.v1 = s.v1 ^ s.v0;
    s.v3 = s.v3 ^ s.v2;
    s.v0 = rotl(s.v0, 32);
    s.v2 = s.v2 + s.v1;
    s.v0 = s.v0 + s.v3;
    s.v1 = rotl(s.v1, 17);
    s.v3 = rotl(s.v3, 21);
    s.v1 = s.v1 ^ s.v2;
    s.v3 = s.v3 ^ s.v0;
    s.v2 = rotl(s.v2, 32);
    return s;
  endfunction

  function automatic lanes_t compress(input lanes_t s, input logic [WordWidth-1:0] m);
    s.v3 = s.v3 ^ m;
    s    = sip_round(sip_round(s));
    s.v0 = s.v0 ^ m;
    return s;
  endfunction

  function automatic lanes_t keyed_lanes(input logic [WordWidth-1:0] k0,
                                         input logic [WordWidth-1:0] k1);
    lanes_t s;
    s.v0 = k0 ^ SipC0;
    s.v1 = k1 ^ SipC1;
    s.v2 = k0 ^ SipC2;
    s.v3 = k1 ^ SipC3;
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $realtime, msg);
    mismatch_count_o++;
  endtask

  // Fold one accepted request into the hash state; queue the digest on an end mark.
  task automatic hash_request(input logic [ByteWidth-1:0] b, input logic present,
                              input logic last);
    if (present || last) begin
      if (!msg_open) begin
        lanes    = keyed_lanes(key_lo, key_hi);
        word_acc = '0;
        slot     = '0;
        msg_len  = '0;
        msg_open = 1'b1;
      end
      if (present) begin
        word_acc = word_acc | ({{(WordWidth-ByteWidth){1'b0}}, b} << (8 * slot));
        msg_len  = msg_len + 8'd1;
        slot     = slot + 3'd1;
        if (slot == '0) begin
          lanes    = compress(lanes, word_acc);
          word_acc = '0;
        end
      end
      if (last) begin
        lanes    = compress(lanes, word_acc | {msg_len, 56'd0});
        lanes.v2 = lanes.v2 ^ SipFinalXor;
        repeat (4) lanes = sip_round(lanes);
        pending_digests.push_back(lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3);
        word_acc = '0;
        slot     = '0;
        msg_len  = '0;
        msg_open = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo           = '0;
      key_hi           = '0;
      lanes            = keyed_lanes('0, '0);
      word_acc         = '0;
      slot             = '0;
      msg_len          = '0;
      msg_open         = 1'b0;
      mismatch_count_o = 0;
      pending_digests.delete();
      digests_due_o   <= 0;
    end else begin
      // Check results before queueing new ones from this edge.
      if (out_valid_i && !out_stall_i) begin
        if (pending_digests.size() == 0) begin
          report_mismatch($sformatf("digest %h with no message pending", digest_i));
        end else begin
          want_digest = pending_digests.pop_front();
          if (digest_i !== want_digest) begin
            report_mismatch($sformatf("digest got %h want %h", digest_i, want_digest));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        hash_request(data_byte_i, byte_present_i, end_of_message_i);
      end
      if (cfg_we_i) begin
        case (reg_index_e'(cfg_index_i))
          REG_KEY_LOW:  key_lo = cfg_wdata_i;
          REG_KEY_HIGH: key_hi = cfg_wdata_i;
          default: ;
        endcase
      end
      digests_due_o <= pending_digests.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
module tb
  import kbsh_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemTarget  = 800;
  localparam int unsigned QuietTail   = 120;
  localparam int unsigned PauseCycles = 20;
  localparam int unsigned IdleLimit   = 1000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_index_i;
  logic [WordWidth-1:0] cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [ByteWidth-1:0] data_byte_i;
  logic                 byte_present_i;
  logic                 end_of_message_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [WordWidth-1:0] digest_o;

  int unsigned mismatch_count;
  int unsigned digests_due;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          gaps_on;
  bit          quiet;

  keyed_byte_stream_hash dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .byte_present_i  (byte_present_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digest_o        (digest_o)
  );

  kbsh_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .byte_present_i  (byte_present_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digest_i        (digest_o),
    .mismatch_count_o(mismatch_count),
    .digests_due_o   (digests_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one request, after an optional gap, and hold it until taken.
  task automatic send_request(input logic [ByteWidth-1:0] b, input logic present,
                              input logic last);
    quiet = (items_sent + QuietTail >= ItemTarget);
    if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    byte_present_i   <= present;
    end_of_message_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (present || last) items_sent++;
  endtask

  task automatic send_message(input int unsigned len, input bit end_alone);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(ByteWidth'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_request(ByteWidth'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !end_alone);
    end
    if (end_alone || len == 0) send_request(ByteWidth'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Hold off until every digest has come back and the core has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (digests_due != 0) @(posedge clk_i);
    repeat (PauseCycles) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [WordWidth-1:0] lo, input logic [WordWidth-1:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_KEY_LOW;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_index_i <= REG_KEY_HIGH;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned          phase;
    int unsigned          len;
    logic [WordWidth-1:0] lo;
    logic [WordWidth-1:0] hi;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = REG_KEY_LOW;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    data_byte_i      = '0;
    byte_present_i   = 1'b0;
    end_of_message_i = 1'b0;
    items_sent       = 0;
    gaps_on          = 1'b1;
    quiet            = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key: empty message, single byte with end mark, ignored empty item.
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'ha5, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    drain();

    // Counting key: end mark on the byte that fills a word, then end mark alone.
    write_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    for (int i = 0; i < 8; i++) send_request(ByteWidth'(i), 1'b1, i == 7);
    for (int i = 0; i < 8; i++) send_request(ByteWidth'(8'hf8 + i), 1'b1, 1'b0);
    send_request(8'h5a, 1'b0, 1'b1);
    drain();

    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase % 5)
        0: begin lo = '1; hi = '1; end
        1: begin lo = '0; hi = '1; end
        3: begin lo = '1; hi = '0; end
        4: begin lo = '0; hi = '0; end
        default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
      endcase
      write_key(lo, hi);
      for (int m = 0; m < 8; m++) begin
        gaps_on = $urandom_range(0, 3) != 0;
        // One long message wraps the length byte.
        len = (phase == 1 && m == 0) ? 264 : $urandom_range(0, 24);
        send_message(len, $urandom_range(0, 3) == 0);
      end
      drain();
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver back-pressure in random bursts; none once the tail starts.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ----- keyed_byte_stream_hash.f -----
+incdir+sv
sv/kbsh_pkg.sv
sv/kbsh_ctrl.sv
sv/kbsh_datapath.sv
sv/keyed_byte_stream_hash.sv
dv/kbsh_checker.sv
dv/tb.sv
